// ===== design/mmbd_pkg.sv =====
// Shared codes, constants and types for the memory map bus decoder.
package mmbd_pkg;

  // Operation codes; the unused code performs no access.
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  // Access size codes; any other code is a word access.
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  // Cartridge image store.
  localparam int unsigned  ROM_AW          = 20;
  localparam logic [31:0]  ROM_STORE_BYTES = 32'h0010_0000;
  localparam int unsigned  ROM_LEN_W       = 21;

  // Byte returned for cartridge bytes past the loaded image.
  localparam logic [7:0]   BYTE_FF         = 8'hFF;

  // Window decode of one bus address.
  typedef struct packed {
    logic video;
    logic video_lane;
    logic rom;
    logic rom_ok;
    logic work;
  } mmbd_hit_t;

endpackage

// ===== design/mmbd_decode.sv =====
// Address window decoder: video RAM, cartridge ROM and work RAM hits and offsets.
module mmbd_decode import mmbd_pkg::*; #(
  parameter logic [31:0] VIDEO_BASE       = 32'h0600_0000,
  parameter logic [31:0] VIDEO_BYTES      = 32'h0001_8000,
  parameter logic [31:0] ROM_WINDOW_BASE  = 32'h0800_0000,
  parameter logic [31:0] ROM_WINDOW_BYTES = 32'h0010_0000,
  parameter logic [31:0] WORK_BASE        = 32'h0200_0000,
  parameter logic [31:0] WORK_BYTES       = 32'h0004_0000,
  parameter int unsigned VID_AW           = 16,
  parameter int unsigned WORK_AW          = 18
) (
  input  logic [31:0]          addr_i,
  input  logic [ROM_LEN_W-1:0] rom_length_i,
  output mmbd_hit_t            hit_o,
  output logic [VID_AW-1:0]    vid_idx_o,
  output logic [ROM_AW-1:0]    rom_off_o,
  output logic [WORK_AW-1:0]   work_off_o
);

  logic [32:0] vid_diff;
  logic [32:0] rom_diff;
  logic [32:0] work_diff;

  // Offset into each window; the top bit flags an address below the base
  assign vid_diff  = {1'b0, addr_i} - {1'b0, VIDEO_BASE};
  assign rom_diff  = {1'b0, addr_i} - {1'b0, ROM_WINDOW_BASE};
  assign work_diff = {1'b0, addr_i} - {1'b0, WORK_BASE};

  // Flag hits and the cartridge bytes that hold loaded image data
  always_comb begin
    hit_o.video      = !vid_diff[32] && (vid_diff[31:0] < VIDEO_BYTES);
    hit_o.video_lane = vid_diff[0];
    hit_o.rom        = !rom_diff[32] && (rom_diff[31:0] < ROM_WINDOW_BYTES);
    hit_o.rom_ok     = (rom_diff[31:0] < {11'b0, rom_length_i}) &&
                       (rom_diff[31:0] < ROM_STORE_BYTES);
    hit_o.work       = !work_diff[32] && (work_diff[31:0] < WORK_BYTES);
  end

  // Halfword index into video RAM drops the lane bit
  assign vid_idx_o  = vid_diff[VID_AW:1];
  assign rom_off_o  = rom_diff[ROM_AW-1:0];
  assign work_off_o = work_diff[WORK_AW-1:0];

endmodule

// ===== design/mmbd_video_ram.sv =====
// Halfword video RAM with per-lane write enables and a registered read port.
module mmbd_video_ram #(
  parameter int unsigned DEPTH = 49152,
  parameter int unsigned AW    = 16
) (
  input  logic          clk_i,
  input  logic [1:0]    we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [15:0]   wdata_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  // Write the enabled lanes, read the whole halfword
  always_ff @(posedge clk_i) begin
    if (we_i[0]) begin
      mem[addr_i][7:0] <= wdata_i[7:0];
    end
    if (we_i[1]) begin
      mem[addr_i][15:8] <= wdata_i[15:8];
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mmbd_byte_ram.sv =====
// Byte-wide single-port RAM with a registered read port.
module mmbd_byte_ram #(
  parameter int unsigned DEPTH = 262144,
  parameter int unsigned AW    = 18
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // Write one byte, read one byte
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/memory_map_bus_decoder.sv =====
// Memory map bus decoder: access sequencer over video, cartridge and work memories.
//
// One access is taken when start is high and busy is low. The sequencer walks the
// access one byte lane per cycle, because each memory has a single port: a read or
// write runs one step per byte lane (1, 2 or 4), a cartridge load or the unused
// opcode runs only the first step, and a wait state follows in which the last
// read byte comes back; busy is high through the steps and the wait state.
// The result word is shown on read_data_o with valid_o high for exactly one cycle
// right after the wait state; busy is already low in that cycle, so the next
// access can be accepted at the edge that ends it. The receiver cannot stall the
// result. Write rom_length through cfg_we_i and cfg_wdata_i only while busy is low.
module memory_map_bus_decoder import mmbd_pkg::*; #(
  parameter logic [31:0] VIDEO_BASE       = 32'h0600_0000,
  parameter logic [31:0] VIDEO_BYTES      = 32'h0001_8000,
  parameter logic [31:0] ROM_WINDOW_BASE  = 32'h0800_0000,
  parameter logic [31:0] ROM_WINDOW_BYTES = 32'h0010_0000,
  parameter logic [31:0] WORK_BASE        = 32'h0200_0000,
  parameter logic [31:0] WORK_BYTES       = 32'h0004_0000
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           operation_i,
  input  logic [1:0]           access_size_i,
  input  logic [31:0]          address_i,
  input  logic [31:0]          write_data_i,
  input  logic                 cfg_we_i,
  input  logic [ROM_LEN_W-1:0] cfg_wdata_i,
  output logic                 valid_o,
  output logic [31:0]          read_data_o
);

  localparam logic [31:0] VIDEO_HALVES = (VIDEO_BYTES + 32'd1) / 32'd2;
  localparam int unsigned VID_AW  = (VIDEO_HALVES > 32'd1) ? $clog2(VIDEO_HALVES) : 1;
  localparam int unsigned WORK_AW = $clog2(WORK_BYTES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_e;

  state_e               state_q;
  logic                 valid_q;
  logic [31:0]          rdata_q;
  logic [ROM_LEN_W-1:0] rom_len_q;
  logic                 cap_q;

  // Item payload
  logic [1:0]  op_q;
  logic [1:0]  size_q;
  logic [31:0] addr_q;
  logic [31:0] data_q;
  logic [1:0]  step_q;
  logic [31:0] acc_q;
  logic [1:0]  cap_idx_q;
  mmbd_hit_t   cap_hit_q;

  logic [1:0]         last_step;
  logic               run;
  logic               is_wr;
  logic               byte_walk;
  logic [31:0]        dec_addr;
  mmbd_hit_t          hit;
  logic [VID_AW-1:0]  vid_idx;
  logic [ROM_AW-1:0]  rom_off;
  logic [WORK_AW-1:0] work_off;

  logic [1:0]         vid_we;
  logic [15:0]        vid_wdata;
  logic [15:0]        vid_rdata;
  logic               work_we;
  logic [WORK_AW-1:0] work_addr;
  logic [7:0]         work_wdata;
  logic [7:0]         work_rdata;
  logic               rom_we;
  logic [ROM_AW-1:0]  rom_addr;
  logic [7:0]         rom_rdata;

  logic [7:0]  rd_byte;
  logic [31:0] acc_m;

  assign run   = (state_q == ST_RUN);
  assign is_wr = run && (op_q == OP_WRITE);
  assign busy  = (state_q != ST_IDLE);

  // Last byte step of the access
  always_comb begin
    last_step = 2'd0;
    if (op_q == OP_READ || op_q == OP_WRITE) begin
      case (size_q)
        SIZE_BYTE: last_step = 2'd0;
        SIZE_HALF: last_step = 2'd1;
        default:   last_step = 2'd3;
      endcase
    end
  end

  // Reads and byte writes decode each byte; halfword and word writes decode each halfword's start
  assign byte_walk = (op_q == OP_READ) || (size_q == SIZE_BYTE);
  assign dec_addr  = byte_walk ? (addr_q + {30'b0, step_q})
                               : (addr_q + {30'b0, step_q[1], 1'b0});

  mmbd_decode #(
    .VIDEO_BASE      (VIDEO_BASE),
    .VIDEO_BYTES     (VIDEO_BYTES),
    .ROM_WINDOW_BASE (ROM_WINDOW_BASE),
    .ROM_WINDOW_BYTES(ROM_WINDOW_BYTES),
    .WORK_BASE       (WORK_BASE),
    .WORK_BYTES      (WORK_BYTES),
    .VID_AW          (VID_AW),
    .WORK_AW         (WORK_AW)
  ) u_decode (
    .addr_i      (dec_addr),
    .rom_length_i(rom_len_q),
    .hit_o       (hit),
    .vid_idx_o   (vid_idx),
    .rom_off_o   (rom_off),
    .work_off_o  (work_off)
  );

  // Video writes: one lane for a byte, both lanes on the first byte of a halfword
  always_comb begin
    vid_we    = 2'b00;
    vid_wdata = {data_q[7:0], data_q[7:0]};
    if (is_wr && hit.video) begin
      if (size_q == SIZE_BYTE) begin
        vid_we = hit.video_lane ? 2'b10 : 2'b01;
      end else if (!step_q[0]) begin
        vid_we    = 2'b11;
        vid_wdata = step_q[1] ? data_q[31:16] : data_q[15:0];
      end
    end
  end

  // Work writes: drop a halfword that would touch the last byte
  always_comb begin
    work_we    = 1'b0;
    work_addr  = work_off;
    work_wdata = data_q[7:0];
    if (is_wr && !hit.video && hit.work) begin
      if (size_q == SIZE_BYTE) begin
        work_we = 1'b1;
      end else if (work_off != WORK_AW'(WORK_BYTES - 32'd1)) begin
        work_we    = 1'b1;
        work_addr  = work_off + WORK_AW'(step_q[0]);
        work_wdata = data_q[{step_q, 3'b000} +: 8];
      end
    end
  end

  // Cartridge loads address the store directly
  assign rom_we   = run && (op_q == OP_LOAD) && (addr_q[31:ROM_AW] == '0);
  assign rom_addr = (op_q == OP_LOAD) ? addr_q[ROM_AW-1:0] : rom_off;

  mmbd_video_ram #(
    .DEPTH(VIDEO_HALVES),
    .AW   (VID_AW)
  ) u_video_ram (
    .clk_i  (clk_i),
    .we_i   (vid_we),
    .addr_i (vid_idx),
    .wdata_i(vid_wdata),
    .rdata_o(vid_rdata)
  );

  mmbd_byte_ram #(
    .DEPTH(WORK_BYTES),
    .AW   (WORK_AW)
  ) u_work_ram (
    .clk_i  (clk_i),
    .we_i   (work_we),
    .addr_i (work_addr),
    .wdata_i(work_wdata),
    .rdata_o(work_rdata)
  );

  mmbd_byte_ram #(
    .DEPTH(ROM_STORE_BYTES),
    .AW   (ROM_AW)
  ) u_rom (
    .clk_i  (clk_i),
    .we_i   (rom_we),
    .addr_i (rom_addr),
    .wdata_i(data_q[7:0]),
    .rdata_o(rom_rdata)
  );

  // Select the returned byte by the window decode registered along with the read
  always_comb begin
    if (cap_hit_q.video) begin
      rd_byte = cap_hit_q.video_lane ? vid_rdata[15:8] : vid_rdata[7:0];
    end else if (cap_hit_q.rom) begin
      rd_byte = cap_hit_q.rom_ok ? rom_rdata : BYTE_FF;
    end else if (cap_hit_q.work) begin
      rd_byte = work_rdata;
    end else begin
      rd_byte = 8'h00;
    end
  end

  // Merge the returned byte into its lane of the read word
  always_comb begin
    acc_m = acc_q;
    if (cap_q) begin
      acc_m[{cap_idx_q, 3'b000} +: 8] = rd_byte;
    end
  end

  // Hold state, the valid flag, the capture flag and the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      rdata_q <= '0;
      cap_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          valid_q <= 1'b0;
          cap_q   <= 1'b0;
          if (start) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          valid_q <= 1'b0;
          cap_q   <= (op_q == OP_READ);
          if (step_q == last_step) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          cap_q   <= 1'b0;
          valid_q <= 1'b1;
          rdata_q <= (op_q == OP_READ) ? acc_m : '0;
          state_q <= ST_IDLE;
        end
        default: begin
          valid_q <= 1'b0;
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Latch the item and advance through its byte steps
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      op_q   <= operation_i;
      size_q <= access_size_i;
      addr_q <= address_i;
      data_q <= write_data_i;
      step_q <= 2'd0;
      acc_q  <= '0;
    end else begin
      acc_q <= acc_m;
      if (run) begin
        step_q <= step_q + 2'd1;
      end
    end
    cap_idx_q <= step_q;
    cap_hit_q <= hit;
  end

  // Hold the cartridge length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_len_q <= '0;
    end else if (cfg_we_i) begin
      rom_len_q <= cfg_wdata_i;
    end
  end

  assign valid_o     = valid_q;
  assign read_data_o = rdata_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the memory map bus decoder: directed edge cases, then random traffic.
module testbench import mmbd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Address map of the instance under test.
  localparam bit [31:0] VIDEO_BASE       = 32'h0600_0000;
  localparam bit [31:0] VIDEO_BYTES      = 32'h0001_8000;
  localparam bit [31:0] ROM_WINDOW_BASE  = 32'h0800_0000;
  localparam bit [31:0] ROM_WINDOW_BYTES = 32'h0010_0000;
  localparam bit [31:0] WORK_BASE        = 32'h0200_0000;
  localparam bit [31:0] WORK_BYTES       = 32'h0004_0000;

  // Codes the package leaves unnamed.
  localparam bit [1:0] SIZE_WORD = 2'd2;
  localparam bit [1:0] SIZE_ODD  = 2'd3;
  localparam bit [1:0] OP_NONE   = 2'd3;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TOUCHED_MAX = 4096;

  typedef struct {
    bit [1:0]  op;
    bit [31:0] address;
    bit [31:0] read_data;
  } bus_reply_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           operation_i = '0;
  logic [1:0]           access_size_i = '0;
  logic [31:0]          address_i = '0;
  logic [31:0]          write_data_i = '0;
  logic                 cfg_we_i = 1'b0;
  logic [ROM_LEN_W-1:0] cfg_wdata_i = '0;
  logic                 valid_o;
  logic [31:0]          read_data_o;

  // Mirror of the memories, one entry per written byte.
  bit [7:0]    vram_bytes [bit [31:0]];
  bit [7:0]    wram_bytes [bit [31:0]];
  bit [7:0]    cart_rom [bit [31:0]];
  bit [31:0]   rom_len = '0;
  bit [31:0]   touched_q [$];
  bus_reply_t  bus_reply_q [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bus_reply_t  due_word;

  memory_map_bus_decoder #(
    .VIDEO_BASE       (VIDEO_BASE),
    .VIDEO_BYTES      (VIDEO_BYTES),
    .ROM_WINDOW_BASE  (ROM_WINDOW_BASE),
    .ROM_WINDOW_BYTES (ROM_WINDOW_BYTES),
    .WORK_BASE        (WORK_BASE),
    .WORK_BYTES       (WORK_BYTES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .access_size_i (access_size_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .valid_o       (valid_o),
    .read_data_o   (read_data_o)
  );

  initial forever #10 clk_i = ~clk_i;

  function automatic bit in_span(bit [31:0] a, bit [31:0] base, bit [31:0] span);
    return a >= base && (a - base) < span;
  endfunction

  function automatic int unsigned lanes_of(bit [1:0] size);
    return (size == SIZE_BYTE) ? 1 : (size == SIZE_HALF) ? 2 : 4;
  endfunction

  // Read one bus byte from the mirror; unmapped bytes are zero, ROM past the image is 0xFF.
  function automatic bit [7:0] bus_byte_at(bit [31:0] a);
    bit [31:0] off;
    if (in_span(a, VIDEO_BASE, VIDEO_BYTES)) begin
      off = a - VIDEO_BASE;
      return vram_bytes.exists(off) ? vram_bytes[off] : 8'h00;
    end
    if (in_span(a, ROM_WINDOW_BASE, ROM_WINDOW_BYTES)) begin
      off = a - ROM_WINDOW_BASE;
      if (off < rom_len && off < ROM_STORE_BYTES)
        return cart_rom.exists(off) ? cart_rom[off] : 8'h00;
      return BYTE_FF;
    end
    if (in_span(a, WORK_BASE, WORK_BYTES)) begin
      off = a - WORK_BASE;
      return wram_bytes.exists(off) ? wram_bytes[off] : 8'h00;
    end
    return 8'h00;
  endfunction

  // True when a byte read has a defined value: unmapped, blank ROM, or written before.
  function automatic bit byte_known(bit [31:0] a);
    if (in_span(a, VIDEO_BASE, VIDEO_BYTES))
      return vram_bytes.exists(a - VIDEO_BASE);
    if (in_span(a, ROM_WINDOW_BASE, ROM_WINDOW_BYTES))
      return (a - ROM_WINDOW_BASE) >= rom_len || cart_rom.exists(a - ROM_WINDOW_BASE);
    if (in_span(a, WORK_BASE, WORK_BYTES))
      return wram_bytes.exists(a - WORK_BASE);
    return 1'b1;
  endfunction

  function automatic bit read_is_safe(bit [31:0] a, bit [1:0] size);
    int unsigned i;
    for (i = 0; i < lanes_of(size); i++)
      if (!byte_known(a + 32'(i))) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void note_touched(bit [31:0] a);
    touched_q.push_back(a);
    if (touched_q.size() > TOUCHED_MAX) void'(touched_q.pop_front());
  endfunction

  function automatic void store_byte(bit [31:0] a, bit [7:0] v);
    if (in_span(a, VIDEO_BASE, VIDEO_BYTES)) begin
      vram_bytes[a - VIDEO_BASE] = v;
      note_touched(a);
    end else if (in_span(a, WORK_BASE, WORK_BYTES)) begin
      wram_bytes[a - WORK_BASE] = v;
      note_touched(a);
    end
  endfunction

  // Video halfwords drop address bit 0; work halfwords touching the last byte are dropped.
  function automatic void store_half(bit [31:0] a, bit [15:0] v);
    bit [31:0] off;
    if (in_span(a, VIDEO_BASE, VIDEO_BYTES)) begin
      off = (a - VIDEO_BASE) & ~32'd1;
      vram_bytes[off] = v[7:0];
      vram_bytes[off + 32'd1] = v[15:8];
      note_touched(VIDEO_BASE + off);
      note_touched(VIDEO_BASE + off + 32'd1);
    end else if (in_span(a, WORK_BASE, WORK_BYTES)) begin
      off = a - WORK_BASE;
      if (off + 32'd1 < WORK_BYTES) begin
        wram_bytes[off] = v[7:0];
        wram_bytes[off + 32'd1] = v[15:8];
        note_touched(a);
        note_touched(a + 32'd1);
      end
    end
  endfunction

  // Apply one bus word to the mirror and return the read data it must produce.
  function automatic bit [31:0] bus_access_effect(bit [1:0] op, bit [1:0] size,
                                                  bit [31:0] a, bit [31:0] d);
    bit [31:0]   word;
    int unsigned i;
    word = '0;
    case (op)
      OP_READ: begin
        for (i = 0; i < lanes_of(size); i++)
          word |= 32'(bus_byte_at(a + 32'(i))) << (8 * i);
      end
      OP_WRITE: begin
        if (size == SIZE_BYTE) begin
          store_byte(a, d[7:0]);
        end else if (size == SIZE_HALF) begin
          store_half(a, d[15:0]);
        end else begin
          store_half(a, d[15:0]);
          store_half(a + 32'd2, d[31:16]);
        end
      end
      OP_LOAD: begin
        if (a < ROM_STORE_BYTES) begin
          cart_rom[a] = d[7:0];
          note_touched(ROM_WINDOW_BASE + a);
        end
      end
      default: ;
    endcase
    return word;
  endfunction

  // Pick a read near written data whose every byte is defined.
  function automatic void pick_safe_read(output bit [31:0] a, output bit [1:0] size);
    int tries;
    for (tries = 0; tries < 8 && touched_q.size() != 0; tries++) begin
      a = touched_q[$urandom_range(0, touched_q.size() - 1)]
          + 32'($urandom_range(0, 6)) - 32'd3;
      size = 2'($urandom_range(0, 3));
      if (read_is_safe(a, size)) return;
    end
    size = SIZE_BYTE;
    if (touched_q.size() != 0) a = touched_q[$urandom_range(0, touched_q.size() - 1)];
    else a = $urandom_range(0, WORK_BASE - 1);
  endfunction

  // Bias offsets toward both ends of a window so reads find written bytes.
  function automatic bit [31:0] random_offset(bit [31:0] span);
    case ($urandom_range(0, 2))
      0:       return $urandom_range(0, 63);
      1:       return span - 32'd1 - 32'($urandom_range(0, 63));
      default: return $urandom_range(0, span - 1);
    endcase
  endfunction

  // Present one word and hold it until the decoder takes it.
  task automatic send_access(bit [1:0] op, bit [1:0] size, bit [31:0] a, bit [31:0] d);
    bus_reply_t reply;
    start         <= 1'b1;
    operation_i   <= op;
    access_size_i <= size;
    address_i     <= a;
    write_data_i  <= d;
    do @(posedge clk_i); while (busy !== 1'b0);
    reply.op = op;
    reply.address = a;
    reply.read_data = bus_access_effect(op, size, a, d);
    bus_reply_q.push_back(reply);
  endtask

  task automatic hold_off_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drop start and wait for every outstanding word to come back.
  task automatic drain_results();
    start <= 1'b0;
    while (bus_reply_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_rom_length(bit [ROM_LEN_W-1:0] len);
    drain_results();
    cfg_wdata_i <= len;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    rom_len = 32'(len);
  endtask

  // Byte lanes, odd alignment and the top edge of video RAM.
  task automatic test_video_lanes();
    send_access(OP_WRITE, SIZE_HALF, VIDEO_BASE + 32'd1, 32'hDEAD_BEEF);
    send_access(OP_WRITE, SIZE_BYTE, VIDEO_BASE + 32'd3, 32'hFFFF_FF5A);
    send_access(OP_WRITE, SIZE_BYTE, VIDEO_BASE + 32'd2, 32'h0000_00A5);
    send_access(OP_READ, SIZE_WORD, VIDEO_BASE, 32'h0);
    send_access(OP_READ, SIZE_HALF, VIDEO_BASE + 32'd1, 32'h0);
    send_access(OP_WRITE, SIZE_WORD, VIDEO_BASE + VIDEO_BYTES - 32'd2, 32'hFFFF_FFFF);
    send_access(OP_READ, SIZE_WORD, VIDEO_BASE + VIDEO_BYTES - 32'd2, 32'h0);
  endtask

  // Dropped halfwords at the last work RAM byte and reads across the window edges.
  task automatic test_work_ram_edges();
    send_access(OP_WRITE, SIZE_BYTE, WORK_BASE + WORK_BYTES - 32'd1, 32'h0000_0011);
    send_access(OP_WRITE, SIZE_HALF, WORK_BASE + WORK_BYTES - 32'd1, 32'hFFFF_FFFF);
    send_access(OP_WRITE, SIZE_WORD, WORK_BASE + WORK_BYTES - 32'd3, 32'h1234_5678);
    send_access(OP_READ, SIZE_WORD, WORK_BASE + WORK_BYTES - 32'd3, 32'h0);
    send_access(OP_WRITE, SIZE_WORD, WORK_BASE, 32'h0000_0000);
    send_access(OP_READ, SIZE_WORD, WORK_BASE - 32'd1, 32'h0);
  endtask

  // Loads, blank cartridge, image length limits and ignored ROM writes.
  task automatic test_cartridge();
    send_access(OP_LOAD, SIZE_BYTE, 32'h0000_0000, 32'h0000_00AB);
    send_access(OP_LOAD, SIZE_WORD, ROM_STORE_BYTES - 32'd1, 32'hFFFF_FFCD);
    send_access(OP_LOAD, SIZE_HALF, ROM_STORE_BYTES, 32'h0000_00EE);
    send_access(OP_LOAD, SIZE_BYTE, 32'h0000_0001, 32'h0000_0001);
    send_access(OP_LOAD, SIZE_BYTE, ROM_STORE_BYTES - 32'd2, 32'h0000_0002);
    send_access(OP_READ, SIZE_WORD, ROM_WINDOW_BASE, 32'h0);
    set_rom_length(ROM_LEN_W'(ROM_STORE_BYTES));
    send_access(OP_READ, SIZE_HALF, ROM_WINDOW_BASE, 32'h0);
    send_access(OP_WRITE, SIZE_BYTE, ROM_WINDOW_BASE, 32'h0000_0000);
    send_access(OP_READ, SIZE_WORD, ROM_WINDOW_BASE + ROM_WINDOW_BYTES - 32'd2, 32'h0);
    set_rom_length(ROM_LEN_W'(1));
    send_access(OP_READ, SIZE_HALF, ROM_WINDOW_BASE, 32'h0);
  endtask

  // Unused operation, size code three as a word, and address wrap.
  task automatic test_odd_codes();
    send_access(OP_NONE, SIZE_ODD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(OP_READ, SIZE_ODD, WORK_BASE + WORK_BYTES - 32'd3, 32'h0);
    send_access(OP_READ, SIZE_WORD, 32'hFFFF_FFFF, 32'h0);
    send_access(OP_WRITE, SIZE_WORD, 32'hFFFF_FFFF, 32'h0F0F_0F0F);
  endtask

  // Mixed traffic: writes and loads, reads mostly near written data, some noise.
  task automatic test_random_traffic(int unsigned count, bit [ROM_LEN_W-1:0] len,
                                     bit with_gaps);
    int unsigned n;
    int unsigned pick;
    bit          gappy;
    bit [1:0]    op;
    bit [1:0]    size;
    bit [31:0]   a;
    bit [31:0]   d;
    set_rom_length(len);
    gappy = 1'b0;
    for (n = 0; n < count; n++) begin
      if (n % 30 == 0) gappy = with_gaps && $urandom_range(0, 2) != 0;
      pick = $urandom_range(0, 99);
      d = $urandom();
      size = 2'($urandom_range(0, 3));
      if (pick < 40) begin
        op = OP_READ;
        pick_safe_read(a, size);
      end else if (pick < 50) begin
        op = OP_READ;
        case ($urandom_range(0, 3))
          0:       a = VIDEO_BASE + random_offset(VIDEO_BYTES);
          1:       a = WORK_BASE + random_offset(WORK_BYTES);
          2:       a = ROM_WINDOW_BASE + random_offset(ROM_WINDOW_BYTES);
          default: a = $urandom();
        endcase
        if (!read_is_safe(a, size)) pick_safe_read(a, size);
      end else if (pick < 80) begin
        op = OP_WRITE;
        if ($urandom_range(0, 1) != 0) a = VIDEO_BASE + random_offset(VIDEO_BYTES);
        else a = WORK_BASE + random_offset(WORK_BYTES);
      end else if (pick < 90) begin
        op = OP_LOAD;
        if ($urandom_range(0, 4) != 0) a = random_offset(ROM_STORE_BYTES);
        else a = $urandom();
      end else begin
        op = 2'($urandom_range(0, 3));
        a = $urandom();
        if (op == OP_READ && !read_is_safe(a, size)) op = OP_NONE;
      end
      send_access(op, size, a, d);
      if (gappy && $urandom_range(0, 2) == 0) hold_off_sender($urandom_range(1, 13));
    end
  endtask

  // Compare each returned word with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) begin
      if (bus_reply_q.size() == 0) begin
        $display("%0t: unexpected result read_data=%h", $time, read_data_o);
        mismatch_count++;
      end else begin
        due_word = bus_reply_q.pop_front();
        if (read_data_o !== due_word.read_data) begin
          $display("%0t: op %0d addr %h read_data expected %h actual %h", $time,
                   due_word.op, due_word.address, due_word.read_data, read_data_o);
          mismatch_count++;
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_rom_length('0);
    test_video_lanes();
    test_work_ram_edges();
    test_cartridge();
    test_odd_codes();
    test_random_traffic(160, ROM_LEN_W'(ROM_STORE_BYTES), 1'b1);
    test_random_traffic(120, '0, 1'b1);
    test_random_traffic(120, ROM_LEN_W'(ROM_STORE_BYTES - 32'd1), 1'b1);
    test_random_traffic(120, ROM_LEN_W'($urandom_range(1, ROM_STORE_BYTES)), 1'b1);
    test_random_traffic(100, ROM_LEN_W'(40), 1'b1);
    test_random_traffic(130, ROM_LEN_W'(ROM_STORE_BYTES), 1'b0);
    drain_results();
    if (mismatch_count == 0 && bus_reply_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== memory_map_bus_decoder.f =====
design/mmbd_pkg.sv
design/mmbd_decode.sv
design/mmbd_video_ram.sv
design/mmbd_byte_ram.sv
design/memory_map_bus_decoder.sv
tb/testbench.sv
